// ===== sv/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet-to-frame reassembler package
// Shared constants, bank entry and control types, and the frame length helper.
// ----------------------------------------------------------------------------
package pfr_pkg;

  // Frame storage geometry.
  localparam int FRAME_MAX = 4096;
  localparam int ADDR_W    = $clog2(FRAME_MAX);
  localparam int FLEN_W    = ADDR_W + 1;
  localparam int CFG_W     = 13;

  // Each bank entry carries a frame epoch; an entry is live only when its
  // tag matches the current epoch of its bank.
  localparam int EP_W = 16;
  localparam logic [EP_W-1:0] EP_ONE   = EP_W'(1);
  localparam logic [EP_W-1:0] EP_LIMIT = {{(EP_W-1){1'b1}}, 1'b0};

  // Item commands.
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Packet position codes.
  localparam logic [3:0] POS_OFF_START = 4'd4;
  localparam logic [3:0] HDR_LEN       = 4'd10;
  localparam logic [3:0] POS_PAYLOAD   = 4'd11;

  typedef struct packed {
    logic [EP_W-1:0] tag;
    logic [7:0]      data;
  } ent_t;

  // Payload byte write from the stream logic.
  typedef struct packed {
    logic              en;
    logic              mem;
    logic [ADDR_W-1:0] addr;
    ent_t              ent;
  } wreq_t;

  // Bank sweep control: address sequencing and rewritten tags.
  typedef struct packed {
    logic              busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [EP_W-1:0]   tag0;
    logic [EP_W-1:0]   tag1;
    logic              done;
  } swp_t;

  typedef struct packed {
    logic [31:0] seen;
    logic [31:0] dropped;
    logic [31:0] events;
    logic [47:0] offset;
  } stats_t;

  // Effective frame length: zero acts as one, large values saturate.
  function automatic logic [FLEN_W-1:0] frame_len(input logic [CFG_W-1:0] fb);
    logic [FLEN_W-1:0] len;
    if (fb == '0) begin
      len = FLEN_W'(1);
    end else if (32'(fb) > FRAME_MAX) begin
      len = FLEN_W'(FRAME_MAX);
    end else begin
      len = FLEN_W'(fb);
    end
    return len;
  endfunction

endpackage

// ===== sv/pfr_bank.sv =====
// ----------------------------------------------------------------------------
// Frame bank memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfr_bank (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [pfr_pkg::ADDR_W-1:0]  wr_addr,
  input  pfr_pkg::ent_t               wr_ent,
  input  logic                        rd_en,
  input  logic [pfr_pkg::ADDR_W-1:0]  rd_addr,
  output pfr_pkg::ent_t               rd_ent
);
  import pfr_pkg::*;

  ent_t mem_r [FRAME_MAX];
  ent_t rd_ent_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_ent;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ent_r <= mem_r[rd_addr];
    end
  end

  assign rd_ent = rd_ent_r;

endmodule

// ===== sv/pfr_sweep.sv =====
// ----------------------------------------------------------------------------
// Bank sweep sequencer
// Walks both banks once, rewriting every tag: a wipe pass invalidates all
// entries, a remap pass moves live entries to epoch one before the epochs wrap.
// ----------------------------------------------------------------------------
module pfr_sweep (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wipe,
  input  logic                      remap,
  input  logic [pfr_pkg::EP_W-1:0]  ep0,
  input  logic [pfr_pkg::EP_W-1:0]  ep1,
  input  logic [pfr_pkg::EP_W-1:0]  rd_tag0,
  input  logic [pfr_pkg::EP_W-1:0]  rd_tag1,
  output pfr_pkg::swp_t             sw
);
  import pfr_pkg::*;

  logic              busy_r,    busy_nxt;
  logic              keep_r,    keep_nxt;
  logic [ADDR_W:0]   cnt_r,     cnt_nxt;
  logic              wb_v_r,    wb_v_nxt;
  logic [ADDR_W-1:0] wb_addr_r, wb_addr_nxt;
  logic              issue;
  logic              finish;

  // A read is issued for each address; the write-back follows in the next cycle.
  assign issue  = busy_r && !cnt_r[ADDR_W];
  assign finish = busy_r && cnt_r[ADDR_W] && !wb_v_r;

  always_comb begin
    busy_nxt    = busy_r;
    keep_nxt    = keep_r;
    cnt_nxt     = issue ? cnt_r + (ADDR_W+1)'(1) : cnt_r;
    wb_v_nxt    = issue;
    wb_addr_nxt = cnt_r[ADDR_W-1:0];
    if (finish) begin
      busy_nxt = 1'b0;
    end
    if (wipe) begin
      busy_nxt = 1'b1;
      keep_nxt = 1'b0;
      cnt_nxt  = '0;
      wb_v_nxt = 1'b0;
    end else if (remap && !busy_r) begin
      busy_nxt = 1'b1;
      keep_nxt = 1'b1;
      cnt_nxt  = '0;
      wb_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      keep_r <= 1'b0;
      cnt_r  <= '0;
      wb_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      keep_r <= keep_nxt;
      cnt_r  <= cnt_nxt;
      wb_v_r <= wb_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= wb_addr_nxt;
  end

  // Sweep control towards both banks.
  always_comb begin
    sw.busy    = busy_r;
    sw.rd_en   = issue;
    sw.rd_addr = cnt_r[ADDR_W-1:0];
    sw.wr_en   = busy_r && wb_v_r;
    sw.wr_addr = wb_addr_r;
    sw.tag0    = (keep_r && rd_tag0 == ep0) ? EP_ONE : '0;
    sw.tag1    = (keep_r && rd_tag1 == ep1) ? EP_ONE : '0;
    sw.done    = finish;
  end

endmodule

// ===== sv/pfr_core.sv =====
// ----------------------------------------------------------------------------
// Stream tracking logic
// Header capture, sequence and offset checks, zero-fill padding, frame fill
// position, statistics and bank epochs. State advances once per item.
// ----------------------------------------------------------------------------
module pfr_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        step,
  input  logic [pfr_pkg::FLEN_W-1:0]  flen,
  input  logic [1:0]                  cmd,
  input  logic [7:0]                  data,
  input  logic                        last,
  input  logic                        pass_done,
  output pfr_pkg::stats_t             stats_nxt,
  output logic [1:0]                  done_cnt,
  output pfr_pkg::wreq_t              wreq,
  output logic                        rd_mem,
  output logic [pfr_pkg::EP_W-1:0]    rd_ep,
  output logic [pfr_pkg::EP_W-1:0]    ep0,
  output logic [pfr_pkg::EP_W-1:0]    ep1
);
  import pfr_pkg::*;

  logic [31:0]       seq_r,  seq_nxt;
  logic [47:0]       offh_r, offh_nxt;
  logic [3:0]        pos_r,  pos_nxt;
  logic [FLEN_W-1:0] fill_r, fill_nxt;
  stats_t            st_r;
  logic              sel_r,  sel_nxt;
  logic [EP_W-1:0]   ep0_r,  ep0_nxt;
  logic [EP_W-1:0]   ep1_r,  ep1_nxt;

  logic              is_byte, in_seq, in_off, in_pay, first;
  logic [2:0]        off_lane;
  logic [31:0]       seq_ins;
  logic [47:0]       off_ins;
  logic [EP_W-1:0]   ep_w, ep_c;
  logic [31:0]       seq_inc;
  logic              seq_gap, need_pad, pad_close, close2, inc_c, inc_w;
  logic [47:0]       gap, off_p;
  logic [FLEN_W-1:0] room, fill_p, fill_w;

  // Position decode.
  assign is_byte  = (cmd == CMD_BYTE);
  assign in_seq   = (pos_r < POS_OFF_START);
  assign in_off   = !in_seq && (pos_r < HDR_LEN);
  assign in_pay   = (pos_r >= HDR_LEN);
  assign first    = (pos_r == HDR_LEN);
  assign off_lane = 3'(pos_r - POS_OFF_START);

  // Little-endian header byte insertion.
  always_comb begin
    seq_ins = seq_r;
    seq_ins[8*pos_r[1:0] +: 8] = data;
    off_ins = offh_r;
    if (in_off) begin
      off_ins[8*off_lane +: 8] = data;
    end
  end

  // Epochs of the working and the completed bank.
  assign ep_w = sel_r ? ep1_r : ep0_r;
  assign ep_c = sel_r ? ep0_r : ep1_r;

  // Header check on the first payload byte and the zero-fill pad.
  assign seq_inc   = st_r.seen + 32'd1;
  assign seq_gap   = (seq_r != seq_inc);
  assign need_pad  = first && (seq_gap || st_r.offset != offh_r);
  assign gap       = offh_r - st_r.offset;
  assign room      = flen - fill_r;
  assign pad_close = need_pad && ((|gap[47:FLEN_W]) || gap[FLEN_W-1:0] >= room);
  assign fill_p    = pad_close ? '0 :
                     need_pad  ? fill_r + gap[FLEN_W-1:0] : fill_r;
  assign off_p     = need_pad ? offh_r : st_r.offset;
  assign fill_w    = fill_p + FLEN_W'(1);
  assign close2    = (fill_w >= flen);

  // A close makes the completed bank the new working one under a fresh epoch.
  assign inc_c = pad_close || close2;
  assign inc_w = pad_close && close2;

  // Item effect on statistics, frame count and the bank write.
  always_comb begin
    stats_nxt = st_r;
    done_cnt  = 2'd0;
    wreq.en   = 1'b0;
    wreq.mem  = sel_r ^ pad_close;
    wreq.addr = fill_p[ADDR_W-1:0];
    wreq.ent  = {(pad_close ? ep_c + EP_ONE : ep_w), data};
    unique case (cmd)
      CMD_BYTE: begin
        if (in_pay) begin
          if (first) begin
            if (seq_gap) begin
              stats_nxt.seen    = seq_r;
              stats_nxt.dropped = st_r.dropped + seq_r + ~st_r.seen;
              stats_nxt.events  = st_r.events + 32'd1;
            end else begin
              stats_nxt.seen = seq_inc;
            end
          end
          stats_nxt.offset = off_p + 48'd1;
          done_cnt         = {1'b0, pad_close} + {1'b0, close2};
          wreq.en          = 1'b1;
        end
      end
      CMD_CLEAR: begin
        stats_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Next state for the stream registers.
  always_comb begin
    seq_nxt  = seq_r;
    offh_nxt = offh_r;
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    sel_nxt  = sel_r;
    ep0_nxt  = ep0_r;
    ep1_nxt  = ep1_r;
    if (is_byte) begin
      if (in_seq) begin
        seq_nxt = seq_ins;
      end
      if (in_off) begin
        offh_nxt = off_ins;
      end
      if (in_pay) begin
        fill_nxt = close2 ? '0 : fill_w;
        sel_nxt  = sel_r ^ pad_close ^ close2;
        if (sel_r) begin
          ep0_nxt = ep0_r + EP_W'(inc_c);
          ep1_nxt = ep1_r + EP_W'(inc_w);
        end else begin
          ep0_nxt = ep0_r + EP_W'(inc_w);
          ep1_nxt = ep1_r + EP_W'(inc_c);
        end
      end
      if (last) begin
        pos_nxt = '0;
      end else if (in_pay) begin
        pos_nxt = POS_PAYLOAD;
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      seq_r  <= '0;
      offh_r <= '0;
      pos_r  <= '0;
      fill_r <= '0;
      st_r   <= '0;
      sel_r  <= 1'b0;
    end else if (step) begin
      seq_r  <= seq_nxt;
      offh_r <= offh_nxt;
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      st_r   <= stats_nxt;
      sel_r  <= sel_nxt;
    end
  end

  // Epochs restart at one after every bank sweep.
  always_ff @(posedge clk) begin
    if (!rst_n || pass_done) begin
      ep0_r <= EP_ONE;
      ep1_r <= EP_ONE;
    end else if (step) begin
      ep0_r <= ep0_nxt;
      ep1_r <= ep1_nxt;
    end
  end

  assign rd_mem = ~sel_r;
  assign rd_ep  = ep_c;
  assign ep0    = ep0_r;
  assign ep1    = ep1_r;

endmodule

// ===== sv/packet_to_frame_reassembler_top.sv =====
// ----------------------------------------------------------------------------
// Packet-to-frame reassembler, top level
// Input register, stream logic, two epoch-tagged frame banks and result
// register. One item is taken every cycle unless a sweep, a pending epoch
// renumbering or output back-pressure holds the input off. Reset and each
// frame_bytes write start a sweep of the banks with the input held off; after
// about 65,500 frames per bank a further sweep renumbers the bank epochs. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module packet_to_frame_reassembler_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_packet_last,
  input  logic [pfr_pkg::ADDR_W-1:0]   in_read_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_frames_done,
  output logic [7:0]                   out_read_data,
  output logic [31:0]                  out_packets_seen,
  output logic [31:0]                  out_packets_dropped,
  output logic [31:0]                  out_drop_events,
  output logic [47:0]                  out_stream_offset,
  input  logic                         cfg_wr_en,
  input  logic [pfr_pkg::CFG_W-1:0]    cfg_wr_data
);
  import pfr_pkg::*;

  logic [CFG_W-1:0]  frame_bytes_r;
  logic [FLEN_W-1:0] flen;

  logic              a_v_r, a_v_nxt;
  logic [1:0]        a_cmd_r;
  logic [7:0]        a_data_r;
  logic              a_last_r;
  logic [ADDR_W-1:0] a_ridx_r;

  logic              o_v_r, o_v_nxt;
  logic [1:0]        o_done_r;
  stats_t            o_stats_r;
  logic              o_rok_r;
  logic              o_msel_r;
  logic [EP_W-1:0]   o_ep_r;

  logic              in_acc, adv, rok, remap_req, remap_go;
  stats_t            stats_nxt;
  logic [1:0]        done_cnt;
  wreq_t             wreq;
  logic              rd_mem;
  logic [EP_W-1:0]   rd_ep, ep0, ep1;
  swp_t              sw;
  ent_t              rd_ent0, rd_ent1, wr_ent0, wr_ent1, o_ent;
  logic              wr_en0, wr_en1, rd_en;
  logic [ADDR_W-1:0] wr_addr0, wr_addr1, rd_addr;

  // Frame length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r <= CFG_W'(FRAME_MAX);
    end else if (cfg_wr_en) begin
      frame_bytes_r <= cfg_wr_data;
    end
  end

  assign flen = frame_len(frame_bytes_r);

  // Handshake: the input register advances when the result register is free.
  assign adv       = a_v_r && (!o_v_r || out_ready);
  assign remap_req = (ep0 >= EP_LIMIT) || (ep1 >= EP_LIMIT);
  assign in_ready  = !sw.busy && !remap_req && (!a_v_r || adv);
  assign in_acc    = in_valid && in_ready;
  assign remap_go  = remap_req && !sw.busy && !a_v_r && !o_v_r && !cfg_wr_en;

  assign a_v_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : a_v_r);
  assign o_v_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : o_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_cmd_r  <= in_command;
      a_data_r <= in_data_byte;
      a_last_r <= in_packet_last;
      a_ridx_r <= in_read_index;
    end
  end

  assign rok = (a_cmd_r == CMD_READ) && ({1'b0, a_ridx_r} < flen);

  // Result register; the bank read data lands alongside it.
  always_ff @(posedge clk) begin
    if (adv) begin
      o_done_r  <= done_cnt;
      o_stats_r <= stats_nxt;
      o_rok_r   <= rok;
      o_msel_r  <= rd_mem;
      o_ep_r    <= rd_ep;
    end
  end

  pfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_wr_en),
    .step      (adv),
    .flen      (flen),
    .cmd       (a_cmd_r),
    .data      (a_data_r),
    .last      (a_last_r),
    .pass_done (sw.done),
    .stats_nxt (stats_nxt),
    .done_cnt  (done_cnt),
    .wreq      (wreq),
    .rd_mem    (rd_mem),
    .rd_ep     (rd_ep),
    .ep0       (ep0),
    .ep1       (ep1)
  );

  pfr_sweep u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .wipe    (cfg_wr_en),
    .remap   (remap_go),
    .ep0     (ep0),
    .ep1     (ep1),
    .rd_tag0 (rd_ent0.tag),
    .rd_tag1 (rd_ent1.tag),
    .sw      (sw)
  );

  // Bank port selection between the sweep and the item stream.
  always_comb begin
    if (sw.busy) begin
      wr_en0   = sw.wr_en;
      wr_en1   = sw.wr_en;
      wr_addr0 = sw.wr_addr;
      wr_addr1 = sw.wr_addr;
      wr_ent0  = {sw.tag0, rd_ent0.data};
      wr_ent1  = {sw.tag1, rd_ent1.data};
      rd_en    = sw.rd_en;
      rd_addr  = sw.rd_addr;
    end else begin
      wr_en0   = adv && wreq.en && !wreq.mem;
      wr_en1   = adv && wreq.en && wreq.mem;
      wr_addr0 = wreq.addr;
      wr_addr1 = wreq.addr;
      wr_ent0  = wreq.ent;
      wr_ent1  = wreq.ent;
      rd_en    = adv && (a_cmd_r == CMD_READ);
      rd_addr  = a_ridx_r;
    end
  end

  pfr_bank u_bank0 (
    .clk     (clk),
    .wr_en   (wr_en0),
    .wr_addr (wr_addr0),
    .wr_ent  (wr_ent0),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_ent  (rd_ent0)
  );

  pfr_bank u_bank1 (
    .clk     (clk),
    .wr_en   (wr_en1),
    .wr_addr (wr_addr1),
    .wr_ent  (wr_ent1),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_ent  (rd_ent1)
  );

  // A completed-frame byte counts only when its epoch is current.
  assign o_ent = o_msel_r ? rd_ent1 : rd_ent0;

  assign out_valid           = o_v_r;
  assign out_frames_done     = o_done_r;
  assign out_read_data       = (o_rok_r && o_ent.tag == o_ep_r) ? o_ent.data : 8'd0;
  assign out_packets_seen    = o_stats_r.seen;
  assign out_packets_dropped = o_stats_r.dropped;
  assign out_drop_events     = o_stats_r.events;
  assign out_stream_offset   = o_stats_r.offset;

  // No item can close more than two frames.
  a_done_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frames_done != 2'd3)
    else $error("frame count per item out of range");

  // A finished sweep leaves both banks on the first epoch.
  a_sweep_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    sw.done |=> (ep0 == EP_ONE && ep1 == EP_ONE))
    else $error("bank epochs not renumbered after sweep");

  // Epochs never wrap to the value held by invalid entries.
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (ep0 != '0) && (ep1 != '0))
    else $error("bank epoch wrapped");

endmodule
